// File: hw/rtl/dsfp_pkg.sv
// Shared types and constants for the distance sensor frame parser.
package dsfp_pkg;

    localparam logic       OP_BYTE       = 1'b0;
    localparam logic       OP_TICK       = 1'b1;

    localparam logic [7:0] HEADER_BYTE   = 8'hFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_SUM    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT    = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } dsfp_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] distance;
    } dsfp_out_t;

    typedef struct packed {
        logic      valid;
        dsfp_out_t data;
    } dsfp_res_t;

endpackage

// File: hw/rtl/distance_sensor_frame_parser_unit.sv
// Distance sensor frame parser top level: handshakes, timeout register and result register.
// Each request is either a received UART byte or one timer tick, and the parser takes one
// request per clock cycle. A frame is 0xFF, high byte, low byte, sum byte; a good sum gives
// the distance, a bad sum or an expired inter-byte timeout gives an error result. Results
// leave from a register in the cycle after the request that closed the frame. s_ready falls
// only while that result register holds a result that m_ready has not taken; otherwise a
// new request is taken every cycle. timeout_ticks (reset 100) reloads on header/data bytes.
module distance_sensor_frame_parser_unit
    import dsfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dsfp_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dsfp_out_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic        accept;
    logic [15:0] timeout_reg;
    logic        m_valid_reg, m_valid_next;
    dsfp_out_t   m_data_reg, m_data_next;
    dsfp_res_t   res;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    dsfp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .item          (s_data),
        .timeout_ticks (timeout_reg),
        .res           (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res.valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("request taken while result register is stalled");

    a_res_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> (m_valid_reg && m_data_reg == $past(res.data)))
        else $error("result not loaded into output register");

    a_stalled_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("stalled result changed before it was taken");

endmodule

// File: hw/rtl/dsfp_parser.sv
// Frame state machine: header hunt, data bytes, checksum and inter-byte timeout.
module dsfp_parser
    import dsfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  dsfp_in_t    item,
    input  logic [15:0] timeout_ticks,
    output dsfp_res_t   res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  high_reg, high_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [7:0]  sum;

    assign sum = HEADER_BYTE + high_reg + low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            high_reg  <= '0;
            low_reg   <= '0;
            ticks_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            ticks_reg <= ticks_next;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        high_next         = high_reg;
        low_next          = low_reg;
        ticks_next        = ticks_reg;
        res.valid         = 1'b0;
        res.data.status   = ST_OK;
        res.data.distance = '0;
        if (accept) begin
            if (item.opcode == OP_TICK) begin
                if (phase_reg != PH_HUNT) begin
                    if (ticks_reg <= 16'd1) begin
                        ticks_next      = '0;
                        phase_next      = PH_HUNT;
                        res.valid       = 1'b1;
                        res.data.status = ST_TIMEOUT;
                    end else begin
                        ticks_next = ticks_reg - 16'd1;
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_HUNT: begin
                        if (item.rx_byte == HEADER_BYTE) begin
                            high_next  = '0;
                            low_next   = '0;
                            phase_next = PH_HIGH;
                            ticks_next = timeout_ticks;
                        end
                    end
                    PH_HIGH: begin
                        high_next  = item.rx_byte;
                        phase_next = PH_LOW;
                        ticks_next = timeout_ticks;
                    end
                    PH_LOW: begin
                        low_next   = item.rx_byte;
                        phase_next = PH_SUM;
                        ticks_next = timeout_ticks;
                    end
                    PH_SUM: begin
                        phase_next = PH_HUNT;
                        ticks_next = '0;
                        res.valid  = 1'b1;
                        if (sum == item.rx_byte) begin
                            res.data.status   = ST_OK;
                            res.data.distance = {high_reg, low_reg};
                        end else begin
                            res.data.status = ST_BAD_SUM;
                        end
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    a_res_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> accept)
        else $error("result without accepted request");

    a_hunt_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && item.opcode == OP_TICK && phase_reg == PH_HUNT) |-> !res.valid)
        else $error("tick while hunting produced a result");

    a_res_returns_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> (phase_reg == PH_HUNT && ticks_reg == 16'd0))
        else $error("parser did not return to header hunt after a result");

endmodule
